// ===== sv/row_color_span_and_gap_defines.svh =====
// ----------------------------------------------------------------------------
// Row color span and gap: assertion macros
// Concurrent assertion helpers clocked on clk with asynchronous reset rst_n.
// ----------------------------------------------------------------------------
`ifndef ROW_COLOR_SPAN_AND_GAP_DEFINES_SVH
`define ROW_COLOR_SPAN_AND_GAP_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property at every rising edge of clk outside reset.
`define RCSG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition never holds outside reset.
`define RCSG_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define RCSG_ASSERT(label, prop, msg)
`define RCSG_NEVER(label, cond, msg)
`endif

`endif

// ===== sv/rcsg_pkg.sv =====
// ----------------------------------------------------------------------------
// Row color span and gap: package
// Payload types of the pixel, result and configuration channels.
// ----------------------------------------------------------------------------
package rcsg_pkg;

    localparam int OUT_COL_W = 13;

    typedef struct packed {
        logic [7:0] pixel_value;
        logic       row_end;
        logic       image_end;
    } pix_t;

    typedef struct packed {
        logic [OUT_COL_W-1:0] first_col;
        logic [OUT_COL_W-1:0] end_col;
        logic [OUT_COL_W-1:0] gap_begin;
        logic [OUT_COL_W-1:0] gap_end;
        logic                 row_found;
        logic                 image_done;
        logic                 any_found;
    } res_t;

    typedef struct packed {
        logic [7:0] target_value;
    } cfg_t;

endpackage

// ===== sv/rcsg_stream_if.sv =====
// ----------------------------------------------------------------------------
// Row color span and gap: stream interface
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface rcsg_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/rcsg_row_tracker.sv =====
// ----------------------------------------------------------------------------
// Row color span and gap: row tracker
// Per-row span and widest interior gap state, updated once per pixel.
// ----------------------------------------------------------------------------
`include "row_color_span_and_gap_defines.svh"

module rcsg_row_tracker #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  rcsg_pkg::pix_t pix,
    input  logic [7:0]    target,
    output logic          has_result,
    output rcsg_pkg::res_t result
);
    import rcsg_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam logic [CW-1:0] MAX_COL = CW'(MAX_WIDTH);

    logic [CW-1:0] col_reg, col_next, col_upd;
    logic [CW-1:0] first_reg, first_next, first_upd;
    logic [CW-1:0] last_end_reg, last_end_next, last_end_upd;
    logic [CW-1:0] gap_start_reg, gap_start_next, gap_start_upd;
    logic [CW-1:0] best_begin_reg, best_begin_next, best_begin_upd;
    logic [CW-1:0] best_end_reg, best_end_next, best_end_upd;
    logic          seen_reg, seen_next, seen_upd;
    logic          in_gap_reg, in_gap_next, in_gap_upd;
    logic          any_reg, any_next, any_upd;
    logic          end_of_row;

    assign end_of_row = pix.row_end | pix.image_end;
    assign has_result = end_of_row;

    // Fold the current pixel into the row state.
    always_comb
    begin
        col_upd        = col_reg;
        first_upd      = first_reg;
        last_end_upd   = last_end_reg;
        gap_start_upd  = gap_start_reg;
        best_begin_upd = best_begin_reg;
        best_end_upd   = best_end_reg;
        seen_upd       = seen_reg;
        in_gap_upd     = in_gap_reg;
        if (col_reg < MAX_COL)
        begin
            if (pix.pixel_value == target)
            begin
                if (!seen_reg)
                begin
                    first_upd = col_reg;
                end
                else if (in_gap_reg &&
                         ((col_reg - gap_start_reg) > (best_end_reg - best_begin_reg)))
                begin
                    best_begin_upd = gap_start_reg;
                    best_end_upd   = col_reg;
                end
                seen_upd     = 1'b1;
                in_gap_upd   = 1'b0;
                last_end_upd = col_reg + CW'(1);
            end
            else if (seen_reg && !in_gap_reg)
            begin
                in_gap_upd    = 1'b1;
                gap_start_upd = col_reg;
            end
            col_upd = col_reg + CW'(1);
        end
        any_upd = any_reg | seen_upd;
    end

    // Build the row result from the updated state.
    always_comb
    begin
        result.first_col  = OUT_COL_W'(seen_upd ? first_upd : col_upd);
        result.end_col    = seen_upd ? OUT_COL_W'(last_end_upd) : '0;
        result.gap_begin  = OUT_COL_W'(best_begin_upd);
        result.gap_end    = OUT_COL_W'(best_end_upd);
        result.row_found  = seen_upd;
        result.image_done = pix.image_end;
        result.any_found  = pix.image_end & any_upd;
    end

    // Hold, advance, or clear at row end.
    always_comb
    begin
        col_next        = col_reg;
        first_next      = first_reg;
        last_end_next   = last_end_reg;
        gap_start_next  = gap_start_reg;
        best_begin_next = best_begin_reg;
        best_end_next   = best_end_reg;
        seen_next       = seen_reg;
        in_gap_next     = in_gap_reg;
        any_next        = any_reg;
        if (step)
        begin
            if (end_of_row)
            begin
                col_next        = '0;
                first_next      = '0;
                last_end_next   = '0;
                gap_start_next  = '0;
                best_begin_next = '0;
                best_end_next   = '0;
                seen_next       = 1'b0;
                in_gap_next     = 1'b0;
                any_next        = pix.image_end ? 1'b0 : any_upd;
            end
            else
            begin
                col_next        = col_upd;
                first_next      = first_upd;
                last_end_next   = last_end_upd;
                gap_start_next  = gap_start_upd;
                best_begin_next = best_begin_upd;
                best_end_next   = best_end_upd;
                seen_next       = seen_upd;
                in_gap_next     = in_gap_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            first_reg      <= '0;
            last_end_reg   <= '0;
            gap_start_reg  <= '0;
            best_begin_reg <= '0;
            best_end_reg   <= '0;
            seen_reg       <= 1'b0;
            in_gap_reg     <= 1'b0;
            any_reg        <= 1'b0;
        end
        else
        begin
            col_reg        <= col_next;
            first_reg      <= first_next;
            last_end_reg   <= last_end_next;
            gap_start_reg  <= gap_start_next;
            best_begin_reg <= best_begin_next;
            best_end_reg   <= best_end_next;
            seen_reg       <= seen_next;
            in_gap_reg     <= in_gap_next;
            any_reg        <= any_next;
        end
    end

    `RCSG_NEVER(a_gap_needs_match, in_gap_reg && !seen_reg, "gap open before any match")
    `RCSG_NEVER(a_col_bound, col_reg > MAX_COL, "column count beyond row limit")
    `RCSG_ASSERT(a_row_clears, step && end_of_row |=> col_reg == '0 && !seen_reg,
                 "row state not cleared after row end")

endmodule

// ===== sv/row_color_span_and_gap.sv =====
// ----------------------------------------------------------------------------
// Row color span and gap: top level
// Per-row span of a target pixel value and its widest interior gap.
// ----------------------------------------------------------------------------
// Usage:
//   pixel  : one pixel per transfer in raster order, with row_end and
//            image_end marks. image_end also closes the current row.
//   result : one transfer per row, issued for the pixel that ends the row.
//   cfg    : writes target_value; write only while the block is idle.
// Result path: a row-ending pixel lands in the input register, and its
//   result is loaded into the result register when that pixel advances.
// Throughput: one pixel per cycle unless a row-ending pixel stalls on a busy
//   result slot; the row tracker sits between the input and result registers.
// Reset: row state, the image-level found flag and target_value clear to
//   zero; no result is pending.
// Stall: while a result waits for result.ready, the input register still
//   advances on pixels that do not end a row; a row-ending pixel holds in
//   the input register until the result slot frees, and pixel.ready drops.
// ----------------------------------------------------------------------------
`include "row_color_span_and_gap_defines.svh"

module row_color_span_and_gap #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic         clk,
    input  logic         rst_n,
    rcsg_stream_if.sink   pixel,
    rcsg_stream_if.source result,
    rcsg_stream_if.sink   cfg
);
    import rcsg_pkg::*;

    logic [7:0] target_reg, target_next;
    pix_t       pix_reg, pix_next;
    logic       pix_valid_reg, pix_valid_next;
    res_t       res_reg, res_next;
    logic       res_valid_reg, res_valid_next;

    logic       row_done;
    res_t       row_res;
    logic       step;
    logic       res_free;

    // Configuration is always taken.
    assign cfg.ready   = 1'b1;
    assign target_next = (cfg.valid) ? cfg.data.target_value : target_reg;

    // Result slot frees when empty or being drained this cycle.
    assign res_free = !res_valid_reg || result.ready;
    // Advance the held pixel unless it needs the result slot and the slot is busy.
    assign step     = pix_valid_reg && (!row_done || res_free);
    assign pixel.ready = !pix_valid_reg || step;

    rcsg_row_tracker #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .pix        (pix_reg),
        .target     (target_reg),
        .has_result (row_done),
        .result     (row_res)
    );

    // Input register: load on transfer, drop when consumed.
    always_comb
    begin
        pix_next       = pix_reg;
        pix_valid_next = pix_valid_reg;
        if (pixel.valid && pixel.ready)
        begin
            pix_next       = pixel.data;
            pix_valid_next = 1'b1;
        end
        else if (step)
        begin
            pix_valid_next = 1'b0;
        end
    end

    // Result register: load a finished row, drop after the transfer.
    always_comb
    begin
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        if (step && row_done)
        begin
            res_next       = row_res;
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= '0;
            pix_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            target_reg    <= target_next;
            pix_valid_reg <= pix_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        pix_reg <= pix_next;
        res_reg <= res_next;
    end

    assign result.valid = res_valid_reg;
    assign result.data  = res_reg;

    `RCSG_ASSERT(a_stall_only_when_busy, !pixel.ready |-> pix_valid_reg && res_valid_reg,
                 "pixel stalled without a pending result")
    `RCSG_ASSERT(a_empty_row_zeros,
                 res_valid_reg && !res_reg.row_found |->
                 res_reg.end_col == '0 && res_reg.gap_begin == '0 && res_reg.gap_end == '0,
                 "row without match reports nonzero span or gap")
    `RCSG_ASSERT(a_any_on_done, res_valid_reg && res_reg.any_found |-> res_reg.image_done,
                 "any_found raised outside image end")

endmodule

// ===== bench/tb_row_color_span_and_gap.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row color span and gap: testbench
// Streams rows of pixels through the block under random idling on the pixel
// and result channels. A directed table covers the reset target, image end
// without row end, ties, trailing runs and extreme values. Random rows follow
// under several target settings. Every result is checked against a
// cycle-free predictor of the row tracker, or against the typed table result.
// ----------------------------------------------------------------------------
module tb_row_color_span_and_gap;

    import rcsg_pkg::*;

    localparam int          ROW_MAX      = 4096;
    localparam int          SETTLE_CYC   = 4;
    localparam int unsigned CYCLE_LIMIT  = 4000000;
    localparam int          RANDOM_ITEMS = 780;
    localparam int          DIR_ROWS     = 22;

    logic clk;
    logic rst_n;

    rcsg_stream_if #(.payload_t(pix_t)) pixel_ch ();
    rcsg_stream_if #(.payload_t(res_t)) result_ch ();
    rcsg_stream_if #(.payload_t(cfg_t)) cfg_ch ();

    row_color_span_and_gap #(
        .MAX_WIDTH(ROW_MAX)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .pixel (pixel_ch),
        .result(result_ch),
        .cfg   (cfg_ch)
    );

    // Clock: 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: a private copy of the row tracker and its target.
    // ------------------------------------------------------------------------
    logic [7:0]  target_q;
    logic [12:0] col_cnt;
    logic [12:0] first_hit;
    logic [12:0] hit_end;
    logic        row_hit;
    logic        gap_open;
    logic [12:0] gap_lo;
    logic [12:0] best_lo;
    logic [12:0] best_hi;
    logic        image_hit;

    // Expected row reports, oldest first.
    res_t row_report_q [$];

    // Results typed into the directed table, keyed by pixel sequence number.
    typedef struct {
        int unsigned seq;
        res_t        want;
    } typed_res_t;
    typed_res_t typed_q [$];

    int unsigned sent_cnt;
    int unsigned accepted_cnt;
    int unsigned fail_cnt;
    int unsigned cycle_cnt;

    bit src_calm;
    bit sink_calm;
    int unsigned sink_hold;

    // Directed table: one pixel per entry, with a typed result where obvious.
    typedef struct {
        pix_t px;
        bit   chk;
        res_t want;
    } dir_row_t;

    dir_row_t dir_tab [DIR_ROWS] = '{
        // Target at column 0 with the reset target of zero.
        '{'{8'd0,   1'b1, 1'b0}, 1'b1, '{13'd0, 13'd1, 13'd0, 13'd0, 1'b1, 1'b0, 1'b0}},
        // Row without target closes the image; earlier row found it.
        '{'{8'd255, 1'b1, 1'b1}, 1'b1, '{13'd1, 13'd0, 13'd0, 13'd0, 1'b0, 1'b1, 1'b1}},
        // Image end without row end still ends the row.
        '{'{8'd255, 1'b0, 1'b1}, 1'b1, '{13'd1, 13'd0, 13'd0, 13'd0, 1'b0, 1'b1, 1'b0}},
        // Two interior gaps, the first one wider.
        '{'{8'd0,   1'b0, 1'b0}, 1'b0, '0},
        '{'{8'd255, 1'b0, 1'b0}, 1'b0, '0},
        '{'{8'd255, 1'b0, 1'b0}, 1'b0, '0},
        '{'{8'd0,   1'b0, 1'b0}, 1'b0, '0},
        '{'{8'd7,   1'b0, 1'b0}, 1'b0, '0},
        '{'{8'd0,   1'b0, 1'b0}, 1'b0, '0},
        '{'{8'd0,   1'b1, 1'b0}, 1'b0, '0},
        // Equal gaps: the earlier one is kept.
        '{'{8'd0,   1'b0, 1'b0}, 1'b0, '0},
        '{'{8'd1,   1'b0, 1'b0}, 1'b0, '0},
        '{'{8'd0,   1'b0, 1'b0}, 1'b0, '0},
        '{'{8'd1,   1'b0, 1'b0}, 1'b0, '0},
        '{'{8'd0,   1'b1, 1'b0}, 1'b0, '0},
        // Leading noise and a trailing run that is never reported.
        '{'{8'd5,   1'b0, 1'b0}, 1'b0, '0},
        '{'{8'd0,   1'b0, 1'b0}, 1'b0, '0},
        '{'{8'd9,   1'b0, 1'b0}, 1'b0, '0},
        '{'{8'd9,   1'b1, 1'b1}, 1'b1, '{13'd1, 13'd2, 13'd0, 13'd0, 1'b1, 1'b1, 1'b1}},
        // Alternating bit patterns, no target.
        '{'{8'hAA,  1'b0, 1'b0}, 1'b0, '0},
        '{'{8'h55,  1'b1, 1'b0}, 1'b1, '{13'd2, 13'd0, 13'd0, 13'd0, 1'b0, 1'b0, 1'b0}},
        // Single-pixel image holding the target.
        '{'{8'd0,   1'b1, 1'b1}, 1'b1, '{13'd0, 13'd1, 13'd0, 13'd0, 1'b1, 1'b1, 1'b1}}
    };

    // Clear the per-row part of the predictor.
    function automatic void clear_row_track();
        col_cnt   = '0;
        first_hit = '0;
        hit_end   = '0;
        row_hit   = 1'b0;
        gap_open  = 1'b0;
        gap_lo    = '0;
        best_lo   = '0;
        best_hi   = '0;
    endfunction

    // Advance the row tracker by one pixel; emit a report when the row ends.
    function automatic void track_pixel(input pix_t p, output bit emit, output res_t r);
        logic [12:0] col;
        logic        any;
        col  = col_cnt;
        emit = 1'b0;
        r    = '0;
        // Columns at and past the saturation width are dropped.
        if (col < ROW_MAX)
        begin
            if (p.pixel_value == target_q)
            begin
                if (!row_hit)
                    first_hit = col;
                else if (gap_open && ((col - gap_lo) > (best_hi - best_lo)))
                begin
                    // Strictly wider only: ties keep the earlier run.
                    best_lo = gap_lo;
                    best_hi = col;
                end
                row_hit  = 1'b1;
                gap_open = 1'b0;
                hit_end  = col + 13'd1;
            end
            else if (row_hit && !gap_open)
            begin
                gap_open = 1'b1;
                gap_lo   = col;
            end
            col_cnt = col + 13'd1;
        end
        if (p.row_end || p.image_end)
        begin
            any          = image_hit || row_hit;
            emit         = 1'b1;
            r.first_col  = row_hit ? first_hit : col_cnt;
            r.end_col    = row_hit ? hit_end : '0;
            r.gap_begin  = best_lo;
            r.gap_end    = best_hi;
            r.row_found  = row_hit;
            r.image_done = p.image_end;
            r.any_found  = p.image_end && any;
            clear_row_track();
            image_hit = p.image_end ? 1'b0 : any;
        end
    endfunction

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_cnt++;
        end
    endfunction

    // Check one row report against the oldest expectation.
    function automatic void check_report(input res_t got);
        res_t want;
        if (row_report_q.size() == 0)
        begin
            $error("row report with no expectation waiting: first_col %0d", got.first_col);
            fail_cnt++;
        end
        else
        begin
            want = row_report_q.pop_front();
            compare_field("first_col",  want.first_col,  got.first_col);
            compare_field("end_col",    want.end_col,    got.end_col);
            compare_field("gap_begin",  want.gap_begin,  got.gap_begin);
            compare_field("gap_end",    want.gap_end,    got.gap_end);
            compare_field("row_found",  want.row_found,  got.row_found);
            compare_field("image_done", want.image_done, got.image_done);
            compare_field("any_found",  want.any_found,  got.any_found);
        end
    endfunction

    // Idle lengths: mostly none or short, a few long; none in calm stretches.
    function automatic int unsigned draw_idle(input bit calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 65)
            return 0;
        else if (r < 94)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: sample all three channels at the rising edge, before any update.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        bit         emit;
        res_t       pred;
        typed_res_t typed;
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                target_q = cfg_ch.data.target_value;
            if (result_ch.valid && result_ch.ready)
                check_report(result_ch.data);
            if (pixel_ch.valid && pixel_ch.ready)
            begin
                track_pixel(pixel_ch.data, emit, pred);
                if (emit)
                begin
                    // A typed table entry for this pixel overrides the predictor.
                    if (typed_q.size() != 0 && typed_q[0].seq == accepted_cnt)
                    begin
                        typed = typed_q.pop_front();
                        pred  = typed.want;
                    end
                    row_report_q.push_back(pred);
                end
                accepted_cnt++;
            end
        end
    end

    // Result sink: stall at random, with calm stretches now and then.
    always @(posedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            sink_calm = !sink_calm;
        if (sink_hold != 0)
        begin
            sink_hold--;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            result_ch.ready <= 1'b1;
            sink_hold = draw_idle(sink_calm);
        end
    end

    // Watchdog: end the run if it hangs.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks. All are entered right after a rising edge.
    // ------------------------------------------------------------------------

    // Present one pixel and hold it until the transfer.
    task automatic push_pixel(input pix_t p);
        pixel_ch.valid <= 1'b1;
        pixel_ch.data  <= p;
        do
            @(posedge clk);
        while (!pixel_ch.ready);
        sent_cnt++;
    endtask

    // Idle for a random gap, then transfer one pixel.
    task automatic send_pixel(input pix_t p);
        int unsigned gap;
        gap = draw_idle(src_calm);
        if (gap != 0)
        begin
            pixel_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push_pixel(p);
    endtask

    // Drop valid and wait until every expected report has come back.
    task automatic drain();
        pixel_ch.valid <= 1'b0;
        @(posedge clk);
        while (row_report_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // Write target_value; the block must be idle.
    task automatic write_target(input logic [7:0] value);
        cfg_ch.valid             <= 1'b1;
        cfg_ch.data.target_value <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Send random rows until the given number of pixels has gone out.
    task automatic run_random_rows(input int unsigned n_items, input logic [7:0] target);
        int unsigned stop_at;
        int unsigned len;
        int unsigned hit_pct;
        int unsigned r;
        bit          img;
        bit          drop_row_end;
        pix_t        p;
        stop_at = sent_cnt + n_items;
        while (sent_cnt < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                len = $urandom_range(1, 12);
            else if (r < 95)
                len = $urandom_range(13, 40);
            else
                len = $urandom_range(41, 200);
            case ($urandom_range(0, 5))
                0:       hit_pct = 0;
                1:       hit_pct = 20;
                2:       hit_pct = 40;
                3:       hit_pct = 60;
                4:       hit_pct = 90;
                default: hit_pct = 100;
            endcase
            img          = ($urandom_range(0, 99) < 15);
            drop_row_end = img && ($urandom_range(0, 99) < 40);
            src_calm     = ($urandom_range(0, 99) < 20);
            for (int unsigned i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 99) < hit_pct)
                    p.pixel_value = target;
                else
                    p.pixel_value = 8'($urandom_range(0, 255));
                p.row_end   = (i == len - 1) && !drop_row_end;
                p.image_end = (i == len - 1) && img;
                send_pixel(p);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        logic [7:0] tgt;
        clk              = 1'b0;
        rst_n            = 1'b0;
        pixel_ch.valid   = 1'b0;
        pixel_ch.data    = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.data      = '0;
        result_ch.ready  = 1'b0;
        sink_hold        = 0;
        sink_calm        = 1'b0;
        src_calm         = 1'b0;
        sent_cnt         = 0;
        accepted_cnt     = 0;
        fail_cnt         = 0;
        cycle_cnt        = 0;
        image_hit        = 1'b0;
        target_q         = '0;
        clear_row_track();

        // Hold reset, then release it at an edge.
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, run with the reset target of zero.
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_tab[i].chk)
                typed_q.push_back('{seq: sent_cnt, want: dir_tab[i].want});
            send_pixel(dir_tab[i].px);
        end
        drain();

        // Random rows under the top extreme, two random targets and zero.
        write_target(8'd255);
        run_random_rows(RANDOM_ITEMS / 4, 8'd255);
        drain();

        tgt = 8'($urandom_range(1, 254));
        write_target(tgt);
        run_random_rows(RANDOM_ITEMS / 4, tgt);
        drain();

        tgt = 8'($urandom_range(0, 255));
        write_target(tgt);
        run_random_rows(RANDOM_ITEMS / 4, tgt);
        drain();

        write_target(8'd0);
        run_random_rows(RANDOM_ITEMS / 4, 8'd0);
        drain();

        // A few more random rows to finish under a fresh target.
        tgt = 8'($urandom_range(0, 255));
        write_target(tgt);
        run_random_rows(40, tgt);
        drain();
        repeat (SETTLE_CYC * 4) @(posedge clk);

        if (fail_cnt == 0 && row_report_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
